FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// clocked property checks shared by the rtl, reset masks every check
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/btp_pkg.sv
// ---------------------------------------------------------------------------
// btp_pkg
// types and fixed constants of the ternary bounding box partition block
// ---------------------------------------------------------------------------
package btp_pkg;

    localparam int FIELD_W   = 12;
    localparam int QUERY_W   = 10;
    localparam int PATH_W    = 8;
    localparam int LEVEL_W   = 3;
    localparam int GROUPS    = 81;
    localparam int GROUP_AW  = 7;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] CLS_STRADDLE = 2'd0;
    localparam logic [1:0] CLS_BELOW    = 2'd1;
    localparam logic [1:0] CLS_ABOVE    = 2'd2;

    typedef struct packed {
        logic               func;
        logic [FIELD_W-1:0] x_low;
        logic [FIELD_W-1:0] x_high;
        logic [FIELD_W-1:0] y_low;
        logic [FIELD_W-1:0] y_high;
        logic               last;
        logic [QUERY_W-1:0] query_index;
    } cmd_t;

    typedef struct packed {
        logic [PATH_W-1:0] leaf_path;
        logic              index_valid;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPAN,
        ST_CLASS
    } state_t;

endpackage

FILE: hw/rtl/bbox_ternary_partition.sv
// ---------------------------------------------------------------------------
// bbox_ternary_partition
// stores connection bounding boxes, splits them into a ternary partition
// over a configurable number of levels and answers leaf path queries
// ---------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------
//  command   | start / busy           | cmd (load box or query path)
//  result    | result_valid strobe    | result (leaf_path, index_valid)
//  config    | cfg_we                 | cfg_wdata (levels)
//
//  loads and queries are accepted while busy is low
//  a query result appears in the cycle after the query beat, for one cycle
//  the last load raises busy for a partition burst: per level one span pass
//  and one class pass over the loaded rows, each bounded by the single read
//  port of the connection memory
//  reset clears counters and flags and sets levels to one, memories hold no reset value
//  the receiver cannot stall, results are never held
//
module bbox_ternary_partition #(
    parameter int MAX_CONNECTIONS = 1024,
    parameter int COORD_BITS      = 12,
    parameter int MAX_LEVELS      = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [btp_pkg::LEVEL_W-1:0]  cfg_wdata,
    input  logic                         start,
    input  btp_pkg::cmd_t                cmd,
    output logic                         busy,
    output logic                         result_valid,
    output btp_pkg::result_t             result
);
    import btp_pkg::*;

    localparam int AW    = $clog2(MAX_CONNECTIONS);
    localparam int CW    = AW + 1;
    localparam int CB    = COORD_BITS;
    localparam int BOX_W = 4 * CB;
    localparam int ROW_W = PATH_W + BOX_W;
    localparam int CMPW  = (CW > QUERY_W) ? CW : QUERY_W;

    // configuration and control
    logic [LEVEL_W-1:0] levels_reg;
    state_t             state_reg, state_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               done_reg, done_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [GROUPS-1:0]  seen_reg, seen_next;
    logic [LEVEL_W-1:0] lv;

    // memories: row = {path, box}, group entry = {low, high}
    logic [ROW_W-1:0]  conn_mem [MAX_CONNECTIONS];
    logic [2*CB-1:0]   group_mem [GROUPS];
    logic [ROW_W-1:0]  conn_rdata_reg;
    logic [2*CB-1:0]   group_rdata_reg;
    logic              conn_we;
    logic [AW-1:0]     conn_waddr, conn_raddr;
    logic [ROW_W-1:0]  conn_wdata;
    logic              group_we;
    logic [GROUP_AW-1:0] group_raddr;
    logic [2*CB-1:0]   group_wdata;

    // pipeline
    logic                p1_valid_reg;
    logic [AW-1:0]       p1_idx_reg;
    logic                p2_valid_reg;
    logic [AW-1:0]       p2_idx_reg;
    logic [GROUP_AW-1:0] p2_g_reg;
    logic [CB-1:0]       p2_lo_reg, p2_hi_reg;
    logic [BOX_W-1:0]    p2_box_reg;
    logic                p3_valid_reg;
    logic [AW-1:0]       p3_idx_reg;
    logic [GROUP_AW-1:0] p3_g_reg;
    logic [CB-1:0]       p3_lo_reg, p3_hi_reg, p3_cut_reg;
    logic [BOX_W-1:0]    p3_box_reg;
    logic                fwd_valid_reg;
    logic [GROUP_AW-1:0] fwd_g_reg;
    logic [2*CB-1:0]     fwd_data_reg;

    // query result
    logic res_valid_reg, res_ok_reg;

    // handshake decode
    logic accept, load_acc, query_acc, load_store;
    logic [CW-1:0] eff_count;
    logic issue, pipe_empty, passes_done, last_level;

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign load_acc   = accept && (cmd.func == FUNC_LOAD);
    assign query_acc  = accept && (cmd.func == FUNC_QUERY);
    // a load after a finished partition opens a fresh set
    assign eff_count  = done_reg ? '0 : count_reg;
    assign load_store = load_acc && (eff_count < CW'(MAX_CONNECTIONS));

    assign lv = (levels_reg == '0) ? LEVEL_W'(1)
              : (levels_reg > LEVEL_W'(MAX_LEVELS)) ? LEVEL_W'(MAX_LEVELS) : levels_reg;

    assign issue       = busy && (idx_reg < count_reg);
    assign pipe_empty  = !p1_valid_reg && !p2_valid_reg && !p3_valid_reg;
    assign passes_done = !issue && pipe_empty;
    assign last_level  = ((level_reg + LEVEL_W'(1)) == lv);

    // ---------------- stage 1: row read back ----------------
    logic [BOX_W-1:0]    s1_box;
    logic [PATH_W-1:0]   s1_path;
    logic [GROUP_AW-1:0] s1_g;
    logic                s1_on_x;
    logic [CB-1:0]       s1_lo, s1_hi;

    always_comb
    begin
        s1_box  = conn_rdata_reg[BOX_W-1:0];
        s1_path = conn_rdata_reg[ROW_W-1 -: PATH_W];
        // first level has one root group; stored paths are stale then
        s1_g    = (level_reg == '0) ? '0 : s1_path[GROUP_AW-1:0];
        // level offset parity follows level parity: x when the global index is even, y at the root
        s1_on_x = (level_reg != '0) && (level_reg[0] == s1_g[0]);
        s1_lo   = s1_on_x ? s1_box[0 +: CB]  : s1_box[2*CB +: CB];
        s1_hi   = s1_on_x ? s1_box[CB +: CB] : s1_box[3*CB +: CB];
    end

    assign group_raddr = s1_g;

    // ---------------- stage 2: group span update or cut ----------------
    logic [CB-1:0] s2_glo, s2_ghi, s2_base_lo, s2_base_hi, s2_new_lo, s2_new_hi;
    logic [CB:0]   s2_cut_wide;
    logic          s2_fwd;

    always_comb
    begin
        s2_glo = group_rdata_reg[2*CB-1:CB];
        s2_ghi = group_rdata_reg[CB-1:0];
        // previous beat may have written the same group while this one was read
        s2_fwd = fwd_valid_reg && (fwd_g_reg == p2_g_reg);
        s2_base_lo = s2_fwd ? fwd_data_reg[2*CB-1:CB] : s2_glo;
        s2_base_hi = s2_fwd ? fwd_data_reg[CB-1:0]    : s2_ghi;
        if (seen_reg[p2_g_reg])
        begin
            s2_new_lo = (p2_lo_reg < s2_base_lo) ? p2_lo_reg : s2_base_lo;
            s2_new_hi = (p2_hi_reg > s2_base_hi) ? p2_hi_reg : s2_base_hi;
        end
        else
        begin
            s2_new_lo = p2_lo_reg;
            s2_new_hi = p2_hi_reg;
        end
        // min + (max - min) / 2 truncated toward zero, rounding up if inverted
        s2_cut_wide = ({1'b0, s2_glo} + {1'b0, s2_ghi}
                      + (CB+1)'(s2_ghi < s2_glo)) >> 1;
    end

    assign group_we    = p2_valid_reg && (state_reg == ST_SPAN);
    assign group_wdata = {s2_new_lo, s2_new_hi};

    // ---------------- stage 3: classify and write path ----------------
    logic [1:0]        s3_cls;
    logic [PATH_W-1:0] s3_path;

    always_comb
    begin
        if (p3_hi_reg < p3_cut_reg)
            s3_cls = CLS_BELOW;
        else if (p3_lo_reg > p3_cut_reg)
            s3_cls = CLS_ABOVE;
        else
            s3_cls = CLS_STRADDLE;
        s3_path = PATH_W'({p3_g_reg, 1'b0}) + PATH_W'(p3_g_reg) + PATH_W'(s3_cls);
    end

    // ---------------- connection memory port muxes ----------------
    always_comb
    begin
        conn_we    = load_store || p3_valid_reg;
        conn_waddr = p3_valid_reg ? p3_idx_reg : eff_count[AW-1:0];
        conn_wdata = p3_valid_reg ? {s3_path, p3_box_reg}
                   : {PATH_W'(0), CB'(cmd.y_high), CB'(cmd.y_low),
                      CB'(cmd.x_high), CB'(cmd.x_low)};
        conn_raddr = busy ? idx_reg[AW-1:0] : AW'(cmd.query_index);
    end

    always_ff @(posedge clk)
    begin
        if (conn_we)
            conn_mem[conn_waddr] <= conn_wdata;
        conn_rdata_reg <= conn_mem[conn_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (group_we)
            group_mem[p2_g_reg] <= group_wdata;
        group_rdata_reg <= group_mem[group_raddr];
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_acc && cmd.last)
                    state_next = ST_SPAN;
            end
            ST_SPAN:
            begin
                if (passes_done)
                    state_next = ST_CLASS;
            end
            ST_CLASS:
            begin
                if (passes_done)
                    state_next = last_level ? ST_IDLE : ST_SPAN;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next   = issue ? idx_reg + CW'(1) : idx_reg;
        level_next = level_reg;
        seen_next  = seen_reg;
        done_next  = done_reg;
        count_next = count_reg;
        if (group_we)
            seen_next[p2_g_reg] = 1'b1;
        if (load_acc)
        begin
            done_next  = 1'b0;
            count_next = load_store ? eff_count + CW'(1) : eff_count;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next   = '0;
                level_next = '0;
                seen_next  = '0;
            end
            ST_SPAN:
            begin
                if (passes_done)
                    idx_next = '0;
            end
            ST_CLASS:
            begin
                if (passes_done)
                begin
                    idx_next   = '0;
                    seen_next  = '0;
                    level_next = level_reg + LEVEL_W'(1);
                    if (last_level)
                        done_next = 1'b1;
                end
            end
            default: idx_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg    <= LEVEL_W'(1);
            state_reg     <= ST_IDLE;
            level_reg     <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            idx_reg       <= '0;
            seen_reg      <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            res_ok_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                levels_reg <= cfg_wdata;
            state_reg     <= state_next;
            level_reg     <= level_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            idx_reg       <= idx_next;
            seen_reg      <= seen_next;
            p1_valid_reg  <= issue;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg && (state_reg == ST_CLASS);
            fwd_valid_reg <= group_we;
            res_valid_reg <= query_acc;
            res_ok_reg    <= query_acc && done_reg
                             && (CMPW'(cmd.query_index) < CMPW'(count_reg));
        end
    end

    // pipeline payload, no reset needed
    always_ff @(posedge clk)
    begin
        p1_idx_reg   <= idx_reg[AW-1:0];
        p2_idx_reg   <= p1_idx_reg;
        p2_g_reg     <= s1_g;
        p2_lo_reg    <= s1_lo;
        p2_hi_reg    <= s1_hi;
        p2_box_reg   <= s1_box;
        p3_idx_reg   <= p2_idx_reg;
        p3_g_reg     <= p2_g_reg;
        p3_lo_reg    <= p2_lo_reg;
        p3_hi_reg    <= p2_hi_reg;
        p3_box_reg   <= p2_box_reg;
        p3_cut_reg   <= s2_cut_wide[CB-1:0];
        fwd_g_reg    <= p2_g_reg;
        fwd_data_reg <= group_wdata;
    end

    // result beat, path straight from the row read register
    assign result_valid       = res_valid_reg;
    assign result.index_valid = res_ok_reg;
    assign result.leaf_path   = res_ok_reg ? conn_rdata_reg[ROW_W-1 -: PATH_W] : '0;

`include "assert_macros.svh"

    `CHK_NEXT(a_query_gives_result, start && !busy && cmd.func == FUNC_QUERY, result_valid, "query beat without result")
    `CHK_IMPL(a_result_from_query, result_valid, $past(start && !busy && cmd.func == FUNC_QUERY), "result without query")
    `CHK_IMPL(a_path_write_in_class, p3_valid_reg, state_reg == ST_CLASS, "path write outside class pass")
    `CHK_IMPL(a_done_at_end, $fell(busy), done_reg, "partition ended without done flag")

endmodule
